>>> rtl/core/uri_percent_decoder_top_macros.svh
// assertion macros shared by the uri percent decoder rtl
`ifndef URI_PERCENT_DECODER_TOP_MACROS_SVH
`define URI_PERCENT_DECODER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define UPD_ASSERT_NOW(label, clk_s, rstn_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define UPD_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/upd_pkg.sv
// shared types, constants and hex helper for the uri percent decoder
package upd_pkg;

    localparam int IdxW = 12;

    localparam logic [7:0] CharNul     = 8'h00;
    localparam logic [7:0] CharPercent = 8'h25;
    localparam logic [7:0] CharQuest   = 8'h3f;
    localparam logic [7:0] CharHash    = 8'h23;
    localparam logic [7:0] CharZero    = 8'h30;
    localparam logic [7:0] CharUpperA  = 8'h41;
    localparam logic [7:0] CaseMask    = 8'hdf;
    localparam logic [7:0] DigitTen    = 8'd10;

    // scan mode, one-hot
    typedef enum logic [4:0] {
        MODE_PATH      = 5'b00001,
        MODE_HEX1      = 5'b00010,
        MODE_HEX2      = 5'b00100,
        MODE_FRAG_SCAN = 5'b01000,
        MODE_IGNORE    = 5'b10000
    } mode_t;

    // one result request
    typedef struct packed {
        logic [7:0]      out_byte;
        logic            is_end;
        logic            illegal;
        logic            has_query;
        logic [IdxW-1:0] query_offset;
    } result_t;

    // loose hex digit value, no digit check, wraps at 8 bits
    function automatic logic [7:0] hex_value(input logic [7:0] x);
        logic [7:0] v;
        if (x >= CharUpperA)
        begin
            v = (x & CaseMask) - CharUpperA + DigitTen;
        end
        else
        begin
            v = x - CharZero;
        end
        return v;
    endfunction

endpackage

>>> rtl/core/uri_percent_decoder_top.sv
// Percent decoder for a uri path, one byte per request, 0 ends the uri. Sustains one request per
// clock while no result is held by out_stall: each byte goes into an input register, the scan
// mode machine decodes it and writes at most one result into the output register, so a result
// is presented after its request has passed the input register and the scan mode machine. The
// output register accepts a new result in the cycle its old one is taken, so the input side only
// stalls while a result is held by out_stall. want_query is written through cfg_valid/cfg_ready
// (always ready) and should change only while the decoder is idle.
`include "uri_percent_decoder_top_macros.svh"

module uri_percent_decoder_top #(
    parameter int MAX_URI_LEN = 4096
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   want_query,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             in_byte,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [7:0]             out_byte,
    output logic                   is_end,
    output logic                   illegal,
    output logic                   has_query,
    output logic [upd_pkg::IdxW-1:0] query_offset
);
    import upd_pkg::*;

    logic       want_query_reg;
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_res_reg;

    logic       out_free;
    logic       step;
    logic       res_valid;
    result_t    res;

    // config register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            want_query_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            want_query_reg <= want_query;
        end
    end

    // handshake: output register frees when empty or taken
    assign out_free = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (!in_stall)
        begin
            in_valid_next = in_valid;
        end
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = step && res_valid;
        end
    end

    // valid registers of the input and output stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= in_byte;
        end
        if (step && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    // decode core
    upd_core #(
        .MAX_URI_LEN (MAX_URI_LEN)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .byte_in    (in_byte_reg),
        .want_query (want_query_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_res_reg.out_byte;
    assign is_end       = out_res_reg.is_end;
    assign illegal      = out_res_reg.illegal;
    assign has_query    = out_res_reg.has_query;
    assign query_offset = out_res_reg.query_offset;

    // status fields are clear on data results
    `UPD_ASSERT_NOW(a_data_status_clear, clk, rst_n, out_valid && !is_end, !illegal && !has_query && (query_offset == '0), "status set on a data result")
    // an escape cut short never reports a query
    `UPD_ASSERT_NOW(a_illegal_no_query, clk, rst_n, out_valid && illegal, is_end && !has_query, "illegal end result reports a query")
    // the input side stalls only behind a held result
    `UPD_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, in_valid_reg && out_valid_reg && out_stall, "input stalled without a held result")

endmodule

>>> rtl/core/upd_core.sv
// scan mode machine: decodes one byte per step and tracks the query start
`include "uri_percent_decoder_top_macros.svh"

module upd_core #(
    parameter int MAX_URI_LEN = 4096
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic [7:0]      byte_in,
    input  logic            want_query,
    output logic            res_valid,
    output upd_pkg::result_t res
);
    import upd_pkg::*;

    localparam int CapInt = (MAX_URI_LEN - 1 > 4095) ? 4095 : (MAX_URI_LEN - 1);
    localparam logic [IdxW-1:0] IdxCap = IdxW'(CapInt);

    mode_t           mode_reg,        mode_next;
    logic [7:0]      first_hex_reg,   first_hex_next;
    logic [IdxW-1:0] byte_index_reg,  byte_index_next;
    logic [IdxW-1:0] query_start_reg, query_start_next;
    logic            query_found_reg, query_found_next;

    logic [IdxW-1:0] idx_inc;
    logic            bad;
    logic [7:0]      hi_val;
    logic [7:0]      lo_val;

    // saturating index of the byte after this one
    assign idx_inc = (byte_index_reg >= IdxCap) ? IdxCap : (byte_index_reg + 1'b1);

    // loose hex values of the two escape bytes
    assign hi_val = hex_value(first_hex_reg);
    assign lo_val = hex_value(byte_in);

    // per-byte decode and state update
    always_comb
    begin
        mode_next        = mode_reg;
        first_hex_next   = first_hex_reg;
        byte_index_next  = byte_index_reg;
        query_start_next = query_start_reg;
        query_found_next = query_found_reg;
        res_valid        = 1'b0;
        res              = '0;
        bad              = mode_reg inside {MODE_HEX1, MODE_HEX2};

        if (step)
        begin
            if (byte_in == CharNul)
            begin
                // end of uri: report status and start over
                res_valid     = 1'b1;
                res.is_end    = 1'b1;
                res.illegal   = bad;
                res.has_query = !bad && query_found_reg;
                if (!bad && query_found_reg)
                begin
                    res.query_offset = query_start_reg;
                end
                mode_next        = MODE_PATH;
                first_hex_next   = '0;
                byte_index_next  = '0;
                query_start_next = '0;
                query_found_next = 1'b0;
            end
            else
            begin
                byte_index_next = idx_inc;
                case (mode_reg)
                    MODE_PATH:
                    begin
                        if (byte_in == CharPercent)
                        begin
                            mode_next = MODE_HEX1;
                        end
                        else if (byte_in == CharQuest)
                        begin
                            if (want_query)
                            begin
                                query_start_next = idx_inc;
                                query_found_next = 1'b1;
                            end
                            mode_next = MODE_IGNORE;
                        end
                        else if (byte_in == CharHash)
                        begin
                            mode_next = want_query ? MODE_FRAG_SCAN : MODE_IGNORE;
                        end
                        else
                        begin
                            res_valid    = 1'b1;
                            res.out_byte = byte_in;
                        end
                    end
                    MODE_HEX1:
                    begin
                        first_hex_next = byte_in;
                        mode_next      = MODE_HEX2;
                    end
                    MODE_HEX2:
                    begin
                        res_valid    = 1'b1;
                        res.out_byte = {hi_val[3:0], 4'b0000} + lo_val;
                        mode_next    = MODE_PATH;
                    end
                    MODE_FRAG_SCAN:
                    begin
                        if (byte_in == CharQuest)
                        begin
                            query_start_next = idx_inc;
                            query_found_next = 1'b1;
                            mode_next        = MODE_IGNORE;
                        end
                    end
                    default:
                    begin
                        mode_next = MODE_IGNORE;
                    end
                endcase
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_PATH;
            first_hex_reg   <= '0;
            byte_index_reg  <= '0;
            query_start_reg <= '0;
            query_found_reg <= 1'b0;
        end
        else
        begin
            mode_reg        <= mode_next;
            first_hex_reg   <= first_hex_next;
            byte_index_reg  <= byte_index_next;
            query_start_reg <= query_start_next;
            query_found_reg <= query_found_next;
        end
    end

    // an end byte returns the scanner to a clean path state
    `UPD_ASSERT_NEXT(a_end_clears, clk, rst_n, step && (byte_in == CharNul), (mode_reg == MODE_PATH) && (byte_index_reg == '0) && !query_found_reg, "scan state not cleared after end of uri")
    // a recorded query start always points past the question mark
    `UPD_ASSERT_NOW(a_query_start_nonzero, clk, rst_n, query_found_reg, (query_start_reg != '0) && (query_start_reg <= IdxCap), "query start out of range")

endmodule
